@@ hw/rtl/mfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Meter frame deframer package
// Byte codes, frame layout constants and the control bundle of a window cell.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // Frame delimiter and coding bytes.
  localparam logic [7:0] SYNC_BYTE     = 8'h68;
  localparam logic [7:0] END_BYTE      = 8'h16;
  localparam logic [7:0] DATA_BIAS     = 8'h33;
  localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;

  // Header plus trailer length, and the largest data field that is accepted.
  localparam int HDR_TRL_LEN = 12;
  localparam int MAX_DATA    = 20;

  // Control bundle that the top level hands to every window cell.
  typedef struct packed {
    logic shift;   // take the neighbor's byte and running sum
    logic check;   // this cell may start a frame that ends with the new beat
    logic head;    // youngest cell: the running sum restarts at zero
  } cell_ctrl_t;

endpackage

@@ hw/rtl/mfd_cell.sv @@
// ----------------------------------------------------------------------------
// Meter frame deframer window cell
// Holds one received byte and the sum of it and all younger bytes but the youngest,
// and flags when it is the opening sync byte of a complete, valid frame.
// ----------------------------------------------------------------------------
module mfd_cell (
  input  logic               clk,
  input  mfd_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         prev_byte,
  input  logic [7:0]         prev_sum,
  input  logic [7:0]         head_byte,
  input  logic [7:0]         tap7,
  input  logic [7:0]         tap9,
  input  logic [7:0]         expect_len,
  output logic [7:0]         cell_byte,
  output logic [7:0]         cell_sum,
  output logic               hit
);

  // On a shift the cell takes its neighbor's byte, and the neighbor's running sum plus
  // the byte that was youngest before the shift; in the youngest cell the sum restarts at zero.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cell_byte <= prev_byte;
      cell_sum  <= ctrl.head ? 8'd0 : 8'(prev_sum + head_byte);
    end
  end

  // A start candidate needs both sync bytes, the length that fits its age and
  // a sum of the frame bytes that equals the checksum byte.
  assign hit = ctrl.check
            && (cell_byte == mfd_pkg::SYNC_BYTE)
            && (tap7 == mfd_pkg::SYNC_BYTE)
            && (tap9 == expect_len)
            && (cell_sum == head_byte);

endmodule

@@ hw/rtl/meter_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// Meter frame deframer
// Finds 0x68-framed meter frames in a stream of received bytes and delivers
// their data bytes with the control byte, address and length of the frame.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------------
//  rx      | rx_valid / rx_stall  | rx_byte
//  res     | res_valid / res_stall| ctrl_code, meter_address, data_count,
//          |                      | data_position, data_value, no_data,
//          |                      | last_of_frame
//
// A byte that completes no frame is handled in order: every cell of the window
// is checked in parallel, then the byte is shifted into the cell chain. A
// preamble byte on an empty window is dropped without entering the chain.
// A completed frame walks the chain out to its oldest cell, then leaves at
// one beat per cycle while res_stall does not hold the output register.
// The window is read out through the oldest cell only, so no byte is taken
// until the last result beat is loaded into the output register.
// Reset empties the window and drops any pending result; a res_stall only
// holds the output register and the readout behind it.
module meter_frame_deframer_unit #(
  parameter int FRAME_CAP = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  ctrl_code,
  output logic [47:0] meter_address,
  output logic [4:0]  data_count,
  output logic [4:0]  data_position,
  output logic [7:0]  data_value,
  output logic        no_data,
  output logic        last_of_frame
);

  localparam int AW = $clog2(FRAME_CAP);
  localparam int CW = $clog2(FRAME_CAP + 1);
  localparam logic [AW-1:0] TOP = AW'(FRAME_CAP - 1);
  localparam logic [CW-1:0] CAP = CW'(FRAME_CAP);

  // Header byte offsets from the opening sync byte.
  localparam logic [3:0] HDR_ADDR0 = 4'd1;
  localparam logic [3:0] HDR_CTRL  = 4'd8;
  localparam logic [3:0] HDR_LEN   = 4'd9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SEEK,
    S_HEAD,
    S_EMIT
  } state_t;

  state_t          state;
  logic [CW-1:0]   fill_count;
  logic [CW-1:0]   fill_eff;
  logic [7:0]      rx_q;
  logic [FRAME_CAP-1:0] hit;
  logic [FRAME_CAP-1:0] hit_q;
  logic [AW-1:0]   enc;
  logic [AW-1:0]   pos;
  logic [3:0]      hdr;
  logic [4:0]      idx;
  logic [7:0]      hdr_ctrl;
  logic [47:0]     hdr_addr;
  logic [7:0]      hdr_len;
  logic [7:0]      win_byte [FRAME_CAP];
  logic [7:0]      win_sum  [FRAME_CAP];
  logic [7:0]      top_byte;
  logic            rx_fire;
  logic            preamble;
  logic            shift_all;
  logic            out_free;
  logic            load_out;
  logic            emit_last;

  // Input handshake and preamble skip.
  assign rx_stall = (state != S_IDLE);
  assign rx_fire  = rx_valid && !rx_stall;
  assign preamble = (fill_count == '0) && (rx_byte == mfd_pkg::PREAMBLE_BYTE);

  // A full window loses its oldest byte first, so that cell is never a start.
  assign fill_eff = (fill_count == CAP) ? CW'(FRAME_CAP - 1) : fill_count;

  // Output register control.
  assign out_free  = !res_valid || !res_stall;
  assign load_out  = (state == S_EMIT) && out_free;
  assign emit_last = (hdr_len == 8'd0) || (idx == 5'(hdr_len[4:0] - 5'd1));
  assign top_byte  = win_byte[FRAME_CAP-1];

  // The whole chain moves together: on insert of a byte that completes no frame,
  // while seeking the frame start, through the header and once per data beat.
  assign shift_all = ((state == S_EVAL) && !(|hit_q))
                  || ((state == S_SEEK) && (pos != TOP))
                  || (state == S_HEAD)
                  || (load_out && (hdr_len != 8'd0));

  // Cell chain, youngest byte at index 0.
  for (genvar j = 0; j < FRAME_CAP; j++) begin : g_cell
    localparam logic [7:0] LEN = (j >= 10) ? 8'(j - 10) : 8'd0;
    localparam bit START_OK = (j >= mfd_pkg::HDR_TRL_LEN - 2)
                           && (j <= mfd_pkg::MAX_DATA + mfd_pkg::HDR_TRL_LEN - 2);
    mfd_pkg::cell_ctrl_t cc;
    logic [7:0] pb;
    logic [7:0] ps;
    logic [7:0] t7;
    logic [7:0] t9;

    if (j == 0) begin : g_head
      assign pb = rx_q;
      assign ps = 8'd0;
    end else begin : g_body
      assign pb = win_byte[j-1];
      assign ps = win_sum[j-1];
    end

    if (j >= 7) begin : g_t7
      assign t7 = win_byte[j-7];
    end else begin : g_n7
      assign t7 = 8'd0;
    end

    if (j >= 9) begin : g_t9
      assign t9 = win_byte[j-9];
    end else begin : g_n9
      assign t9 = 8'd0;
    end

    assign cc.shift = shift_all;
    assign cc.check = START_OK && rx_fire && (rx_byte == mfd_pkg::END_BYTE)
                   && (CW'(j) < fill_eff);
    assign cc.head  = (j == 0);

    mfd_cell u_cell (
      .clk        (clk),
      .ctrl       (cc),
      .prev_byte  (pb),
      .prev_sum   (ps),
      .head_byte  (win_byte[0]),
      .tap7       (t7),
      .tap9       (t9),
      .expect_len (LEN),
      .cell_byte  (win_byte[j]),
      .cell_sum   (win_sum[j]),
      .hit        (hit[j])
    );
  end

  // The oldest matching start wins.
  always_comb begin
    enc = '0;
    for (int j = 0; j < FRAME_CAP; j++) begin
      if (hit_q[j]) begin
        enc = AW'(j);
      end
    end
  end

  // Sequencer, fill count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (rx_fire && !preamble) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (|hit_q) begin
            fill_count <= '0;
            state      <= S_SEEK;
          end else begin
            if (fill_count != CAP) begin
              fill_count <= fill_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_SEEK: begin
          if (pos == TOP) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (hdr == HDR_LEN) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_out && emit_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end

    // Datapath registers need no reset.
    if (rx_fire) begin
      rx_q  <= rx_byte;
      hit_q <= hit;
    end

    if (state == S_EVAL) begin
      pos <= enc;
    end else if ((state == S_SEEK) && (pos != TOP)) begin
      pos <= pos + 1'b1;
    end

    if (state == S_SEEK) begin
      hdr <= '0;
    end else if (state == S_HEAD) begin
      hdr <= hdr + 1'b1;
    end

    // Header capture as the bytes pass the oldest cell.
    if (state == S_HEAD) begin
      for (int i = 0; i < 6; i++) begin
        if (hdr == 4'(HDR_ADDR0 + 4'(i))) begin
          hdr_addr[8*i +: 8] <= top_byte;
        end
      end
      if (hdr == HDR_CTRL) begin
        hdr_ctrl <= top_byte;
      end
      if (hdr == HDR_LEN) begin
        hdr_len <= top_byte;
      end
      idx <= '0;
    end

    if (load_out) begin
      idx           <= idx + 1'b1;
      ctrl_code     <= hdr_ctrl;
      meter_address <= hdr_addr;
      data_count    <= hdr_len[4:0];
      data_position <= (hdr_len == 8'd0) ? 5'd0 : idx;
      data_value    <= (hdr_len == 8'd0) ? 8'd0 : 8'(top_byte - mfd_pkg::DATA_BIAS);
      no_data       <= (hdr_len == 8'd0);
      last_of_frame <= emit_last;
    end
  end

  // The window never holds more bytes than it has cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CAP)
    else $error("fill count beyond window size");

  // A detected frame empties the window.
  a_match_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) && (|hit_q) |=> (fill_count == '0))
    else $error("window not emptied after frame match");

  // Only frames with a legal data length reach the readout.
  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (hdr_len <= 8'(mfd_pkg::MAX_DATA)))
    else $error("data length out of range during readout");

  // The final beat of a frame hands the sequencer back to the input side.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    load_out && emit_last |=> (state == S_IDLE) && res_valid && last_of_frame)
    else $error("sequencer not idle after final beat");

endmodule
